@@ hdl/slc_pkg.sv @@
// package of shared types and codes for the set-associative lru cache simulator
`default_nettype none

package slc_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_STORE  = 2'd1;
   localparam logic [1:0] FUNC_MODIFY = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   localparam logic [1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS  = 2'd1;
   localparam logic [1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam logic [3:0] SET_BITS_RST    = 4'd4;
   localparam logic [4:0] BLOCK_BITS_RST  = 5'd4;
   localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;

   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [4:0] set_bits;
      logic [4:0] block_bits;
      logic [5:0] nways;
   } cfg_type;

endpackage

`default_nettype wire

@@ hdl/slc_cfg.sv @@
// configuration registers with range clamping
`default_nettype none

module slc_cfg
   import slc_pkg::*;
#(
   parameter int MAX_SET_BITS = 10,
   parameter int MAX_WAYS     = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [4:0] csr_wdata,
   output cfg_type         cfg
);

   logic [3:0] set_bits_ff, set_bits_in;
   logic [4:0] block_bits_ff, block_bits_in;
   logic [3:0] ways_ff, ways_in;

   assign csr_ready = 1'b1;

   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_in       = ways_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SET_BITS:    set_bits_in   = csr_wdata[3:0];
            CSR_BLOCK_BITS:  block_bits_in = csr_wdata;
            CSR_WAYS_IN_USE: ways_in       = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SET_BITS_RST;
         block_bits_ff <= BLOCK_BITS_RST;
         ways_ff       <= WAYS_IN_USE_RST;
      end else begin
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_ff       <= ways_in;
      end
   end

   always_comb begin
      if ({1'b0, set_bits_ff} > 5'(MAX_SET_BITS))
         cfg.set_bits = 5'(MAX_SET_BITS);
      else
         cfg.set_bits = {1'b0, set_bits_ff};
      cfg.block_bits = block_bits_ff;
      if (ways_ff == 4'd0)
         cfg.nways = 6'd1;
      else if ({2'b00, ways_ff} > 6'(MAX_WAYS))
         cfg.nways = 6'(MAX_WAYS);
      else
         cfg.nways = {2'b00, ways_ff};
   end

endmodule

`default_nettype wire

@@ hdl/slc_store.sv @@
// line state and tag memories with the clearing pass after reset
`default_nettype none

module slc_store #(
   parameter int SET_W = 10,
   parameter int WAY_W = 3,
   parameter int ROW_W = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   output logic                        clear_done,
   input  wire logic                   meta_rd_en,
   input  wire logic [SET_W-1:0]       meta_rd_addr,
   output logic [ROW_W-1:0]            meta_rd_data,
   input  wire logic                   meta_wr_en,
   input  wire logic [SET_W-1:0]       meta_wr_addr,
   input  wire logic [ROW_W-1:0]       meta_wr_data,
   input  wire logic [SET_W+WAY_W-1:0] tag_rd_addr,
   output logic [31:0]                 tag_rd_data,
   input  wire logic                   tag_wr_en,
   input  wire logic [SET_W+WAY_W-1:0] tag_wr_addr,
   input  wire logic [31:0]            tag_wr_data
);

   localparam int NUM_SETS  = 1 << SET_W;
   localparam int TAG_DEPTH = 1 << (SET_W + WAY_W);

   logic [ROW_W-1:0] meta_mem [NUM_SETS];
   logic [31:0]      tag_mem  [TAG_DEPTH];
   logic [SET_W:0]   clr_ff, clr_in;

   assign clear_done = (clr_ff == (SET_W+1)'(NUM_SETS));
   assign clr_in     = clear_done ? clr_ff : clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         clr_ff <= '0;
      else
         clr_ff <= clr_in;
   end

   always_ff @(posedge clock) begin
      if (!clear_done)
         meta_mem[clr_ff[SET_W-1:0]] <= '0;
      else if (meta_wr_en)
         meta_mem[meta_wr_addr] <= meta_wr_data;
      if (meta_rd_en)
         meta_rd_data <= meta_mem[meta_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tag_wr_en)
         tag_mem[tag_wr_addr] <= tag_wr_data;
      tag_rd_data <= tag_mem[tag_rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/set_assoc_lru_cache_sim_unit.sv @@
// top level of the set-associative lru cache simulator
//
// An access is taken on start while busy is low: req_func gives the kind
// (load, store, modify) and req_address the byte address; kind 3 is taken
// and dropped. Registers are written on csr_valid (csr_ready stays high):
// index 0 set bits, 1 block bits, 2 ways in use.
// Each access reads the set's line state row, then steps one way per
// cycle through a single tag compare and rank compare unit, then writes
// the updated row back; it scans n ways, n being ways_in_use held to
// 1 .. MAX_WAYS. A modify runs two accesses. The result appears on the
// rsp_ ports for one cycle with rsp_valid high, the cycle after the
// write-back, with rsp_last_of_item high on the last result of a request
// (low on the first result of a modify). The receiver cannot stall:
// every strobe is one transfer.
// After reset is released busy stays high while the line state memory is
// cleared one set per cycle; register writes are taken meanwhile.
`default_nettype none

module set_assoc_lru_cache_sim_unit
   import slc_pkg::*;
#(
   parameter int MAX_SET_BITS = 10,
   parameter int MAX_WAYS     = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_address,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic             rsp_miss,
   output logic             rsp_eviction,
   output logic             rsp_last_of_item,
   output logic [31:0]      rsp_hits_so_far,
   output logic [31:0]      rsp_misses_so_far,
   output logic [31:0]      rsp_evictions_so_far,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_wdata
);

   localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W = WAY_W;
   localparam int ROW_W  = MAX_WAYS * (1 + RANK_W);
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic                     clear_done;
   logic                     meta_rd_en;
   logic [ROW_W-1:0]         meta_rd_data;
   logic                     meta_wr_en;
   logic [ROW_W-1:0]         meta_wr_data;
   logic [SET_W+WAY_W-1:0]   tag_rd_addr;
   logic [31:0]              tag_rd_data;
   logic                     tag_wr_en;

   logic [SET_W-1:0] set_ff, set_in;
   logic [31:0]      tag_ff, tag_in;
   logic             second_ff, second_in;
   logic [WAY_W-1:0] scan_ff, scan_in;
   logic             hit_found_ff, hit_found_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in;
   logic             empty_found_ff, empty_found_in;
   logic [WAY_W-1:0] empty_way_ff, empty_way_in;
   logic [RANK_W-1:0] best_ff, best_in;
   logic [WAY_W-1:0] victim_ff, victim_in;

   logic [31:0] hit_cnt_ff, hit_cnt_in;
   logic [31:0] miss_cnt_ff, miss_cnt_in;
   logic [31:0] evict_cnt_ff, evict_cnt_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic rsp_evict_ff, rsp_evict_in;
   logic rsp_last_ff, rsp_last_in;

   logic              accept;
   logic [31:0]       shifted;
   logic [5:0]        split;
   logic [SET_W-1:0]  req_set;
   logic [31:0]       req_tag;
   logic              valid_v [MAX_WAYS];
   logic [RANK_W-1:0] rank_v  [MAX_WAYS];
   logic              cur_valid;
   logic [RANK_W-1:0] cur_rank;
   logic              tag_match;
   logic              last_way;
   logic [WAY_W-1:0]  upd_way;
   logic              was_valid;
   logic [RANK_W-1:0] old_rank;
   logic              is_evict;

   slc_cfg #(
      .MAX_SET_BITS(MAX_SET_BITS),
      .MAX_WAYS(MAX_WAYS)
   ) u_cfg (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   slc_store #(
      .SET_W(SET_W),
      .WAY_W(WAY_W),
      .ROW_W(ROW_W)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .clear_done(clear_done),
      .meta_rd_en(meta_rd_en),
      .meta_rd_addr(set_ff),
      .meta_rd_data(meta_rd_data),
      .meta_wr_en(meta_wr_en),
      .meta_wr_addr(set_ff),
      .meta_wr_data(meta_wr_data),
      .tag_rd_addr(tag_rd_addr),
      .tag_rd_data(tag_rd_data),
      .tag_wr_en(tag_wr_en),
      .tag_wr_addr({set_ff, upd_way}),
      .tag_wr_data(tag_ff)
   );

   // address split
   always_comb begin
      shifted = req_address >> cfg.block_bits;
      split   = {1'b0, cfg.set_bits} + {1'b0, cfg.block_bits};
      for (int i = 0; i < SET_W; i++)
         req_set[i] = shifted[i] & (5'(i) < cfg.set_bits);
      if (split >= 6'd32)
         req_tag = '0;
      else
         req_tag = req_address >> split[4:0];
   end

   // row unpack
   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         valid_v[i] = meta_rd_data[i];
         rank_v[i]  = meta_rd_data[MAX_WAYS + i*RANK_W +: RANK_W];
      end
   end

   assign accept    = start && !busy;
   assign cur_valid = valid_v[scan_ff];
   assign cur_rank  = rank_v[scan_ff];
   assign tag_match = (tag_rd_data == tag_ff);
   assign last_way  = (6'(scan_ff) == cfg.nways - 6'd1);

   always_comb begin
      if (hit_found_ff)
         upd_way = hit_way_ff;
      else if (empty_found_ff)
         upd_way = empty_way_ff;
      else
         upd_way = victim_ff;
   end

   assign was_valid = hit_found_ff || !empty_found_ff;
   assign is_evict  = !hit_found_ff && !empty_found_ff;
   assign old_rank  = rank_v[upd_way];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (accept && req_func != FUNC_NONE) state_in = ST_READ;
         ST_READ:   state_in = ST_SCAN;
         ST_SCAN:   if (last_way) state_in = ST_UPDATE;
         ST_UPDATE: state_in = second_ff ? ST_READ : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy       = 1'b1;
      meta_rd_en = 1'b0;
      meta_wr_en = 1'b0;
      tag_wr_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   busy = 1'b0;
         ST_READ:   meta_rd_en = 1'b1;
         ST_UPDATE: begin
            meta_wr_en = 1'b1;
            tag_wr_en  = !hit_found_ff;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      set_in         = set_ff;
      tag_in         = tag_ff;
      second_in      = second_ff;
      scan_in        = scan_ff;
      hit_found_in   = hit_found_ff;
      hit_way_in     = hit_way_ff;
      empty_found_in = empty_found_ff;
      empty_way_in   = empty_way_ff;
      best_in        = best_ff;
      victim_in      = victim_ff;
      hit_cnt_in     = hit_cnt_ff;
      miss_cnt_in    = miss_cnt_ff;
      evict_cnt_in   = evict_cnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evict_in   = rsp_evict_ff;
      rsp_last_in    = rsp_last_ff;
      tag_rd_addr    = {set_ff, scan_ff + 1'b1};
      meta_wr_data   = meta_rd_data;
      case (state_ff)
         ST_IDLE: begin
            set_in    = req_set;
            tag_in    = req_tag;
            second_in = (req_func == FUNC_MODIFY);
         end
         ST_READ: begin
            tag_rd_addr    = {set_ff, {WAY_W{1'b0}}};
            scan_in        = '0;
            hit_found_in   = 1'b0;
            empty_found_in = 1'b0;
            best_in        = '0;
            victim_in      = '0;
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (cur_valid && tag_match && !hit_found_ff) begin
               hit_found_in = 1'b1;
               hit_way_in   = scan_ff;
            end
            if (!cur_valid && !empty_found_ff) begin
               empty_found_in = 1'b1;
               empty_way_in   = scan_ff;
            end
            if (cur_rank > best_ff) begin
               best_in   = cur_rank;
               victim_in = scan_ff;
            end
         end
         ST_UPDATE: begin
            for (int i = 0; i < MAX_WAYS; i++) begin
               if (WAY_W'(i) == upd_way) begin
                  meta_wr_data[i] = 1'b1;
                  meta_wr_data[MAX_WAYS + i*RANK_W +: RANK_W] = '0;
               end else if ((6'(i) < cfg.nways) && valid_v[i] &&
                            (!was_valid || rank_v[i] < old_rank) &&
                            rank_v[i] != RANK_MAX) begin
                  meta_wr_data[MAX_WAYS + i*RANK_W +: RANK_W] = rank_v[i] + 1'b1;
               end
            end
            if (hit_found_ff) begin
               if (hit_cnt_ff != CNT_MAX) hit_cnt_in = hit_cnt_ff + 1'b1;
            end else begin
               if (miss_cnt_ff != CNT_MAX) miss_cnt_in = miss_cnt_ff + 1'b1;
            end
            if (is_evict && evict_cnt_ff != CNT_MAX)
               evict_cnt_in = evict_cnt_ff + 1'b1;
            second_in    = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = hit_found_ff;
            rsp_evict_in = is_evict;
            rsp_last_in  = !second_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         second_ff    <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         evict_cnt_ff <= evict_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff         <= set_in;
      tag_ff         <= tag_in;
      scan_ff        <= scan_in;
      hit_found_ff   <= hit_found_in;
      hit_way_ff     <= hit_way_in;
      empty_found_ff <= empty_found_in;
      empty_way_ff   <= empty_way_in;
      best_ff        <= best_in;
      victim_ff      <= victim_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evict_ff   <= rsp_evict_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_miss             = !rsp_hit_ff;
   assign rsp_eviction         = rsp_evict_ff;
   assign rsp_last_of_item     = rsp_last_ff;
   assign rsp_hits_so_far      = hit_cnt_ff;
   assign rsp_misses_so_far    = miss_cnt_ff;
   assign rsp_evictions_so_far = evict_cnt_ff;

   // no access may start before the clearing pass is over
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> busy)
      else $error("access window open during clearing pass");

   // an eviction result is always a miss
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_eviction |-> rsp_miss)
      else $error("eviction without miss");

   // a first result of a modify is followed by its second access
   a_modify_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_item |-> state_ff == ST_READ && busy)
      else $error("second access of modify missing");

   // every write-back gives exactly one result strobe
   a_update_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |=> rsp_valid && $past(meta_wr_en))
      else $error("write-back without result");

endmodule

`default_nettype wire

@@ verif/set_assoc_lru_cache_sim_unit_tb.sv @@
// self-checking testbench for the set-associative lru cache simulator
`timescale 1ns / 100ps

module set_assoc_lru_cache_sim_unit_tb;
   import slc_pkg::*;

   localparam int SET_LIMIT     = 10;
   localparam int WAY_LIMIT     = 8;
   localparam int SET_COUNT     = 1 << SET_LIMIT;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 122;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic        hit;
      logic        miss;
      logic        eviction;
      logic        last;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evictions;
   } lookup_result_type;

   class cache_model_type;
      bit                way_valid [SET_COUNT][WAY_LIMIT];
      logic [31:0]       way_tag   [SET_COUNT][WAY_LIMIT];
      bit [2:0]          way_rank  [SET_COUNT][WAY_LIMIT];
      logic [31:0]       hit_total;
      logic [31:0]       miss_total;
      logic [31:0]       evict_total;
      logic [3:0]        set_bits;
      logic [4:0]        block_bits;
      logic [3:0]        ways_in_use;
      lookup_result_type expected_lookups [$];
      int                mismatch_count;

      function new();
         foreach (way_valid[i, j]) begin
            way_valid[i][j] = 1'b0;
            way_tag[i][j]   = '0;
            way_rank[i][j]  = '0;
         end
         hit_total      = '0;
         miss_total     = '0;
         evict_total    = '0;
         set_bits       = SET_BITS_RST;
         block_bits     = BLOCK_BITS_RST;
         ways_in_use    = WAYS_IN_USE_RST;
         mismatch_count = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [4:0] val);
         case (idx)
            CSR_SET_BITS:    set_bits    = val[3:0];
            CSR_BLOCK_BITS:  block_bits  = val;
            CSR_WAYS_IN_USE: ways_in_use = val[3:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_lookups.size();
      endfunction

      function void lookup(int unsigned st, logic [31:0] tg, int unsigned nw, bit last);
         bit                hit;
         bit                evict;
         bit                found;
         bit                was_valid;
         int unsigned       w;
         int unsigned       best;
         int unsigned       old;
         lookup_result_type r;
         hit   = 1'b0;
         evict = 1'b0;
         found = 1'b0;
         w     = 0;
         best  = 0;
         for (int i = 0; i < nw; i++)
            if (!hit && way_valid[st][i] && way_tag[st][i] == tg) begin
               hit = 1'b1;
               w   = i;
            end
         if (hit) begin
            if (hit_total != CNT_MAX) hit_total++;
            was_valid = 1'b1;
         end else begin
            if (miss_total != CNT_MAX) miss_total++;
            for (int i = 0; i < nw; i++)
               if (!found && !way_valid[st][i]) begin
                  found = 1'b1;
                  w     = i;
               end
            if (!found) begin
               evict = 1'b1;
               if (evict_total != CNT_MAX) evict_total++;
               w = 0;
               // oldest way, lowest number among equal ranks
               for (int i = 0; i < nw; i++)
                  if (way_rank[st][i] > best) begin
                     best = way_rank[st][i];
                     w    = i;
                  end
            end
            was_valid        = !found;
            way_valid[st][w] = 1'b1;
            way_tag[st][w]   = tg;
         end
         old = way_rank[st][w];
         for (int i = 0; i < nw; i++)
            if (i != w && way_valid[st][i] && (!was_valid || way_rank[st][i] < old)
                && way_rank[st][i] < WAY_LIMIT - 1)
               way_rank[st][i]++;
         way_rank[st][w] = '0;
         r.hit       = hit;
         r.miss      = !hit;
         r.eviction  = evict;
         r.last      = last;
         r.hits      = hit_total;
         r.misses    = miss_total;
         r.evictions = evict_total;
         expected_lookups.push_back(r);
      endfunction

      function void note_access(logic [1:0] func, logic [31:0] addr);
         int unsigned s;
         int unsigned b;
         int unsigned nw;
         int unsigned st;
         logic [31:0] tg;
         if (func == FUNC_NONE) return;
         s  = (set_bits > SET_LIMIT) ? SET_LIMIT : set_bits;
         b  = block_bits;
         nw = ways_in_use;
         if (nw < 1) nw = 1;
         if (nw > WAY_LIMIT) nw = WAY_LIMIT;
         st = (addr >> b) & ((32'd1 << s) - 32'd1);
         tg = (s + b >= 32) ? 32'd0 : (addr >> (s + b));
         if (func == FUNC_MODIFY) begin
            lookup(st, tg, nw, 1'b0);
            lookup(st, tg, nw, 1'b1);
         end else begin
            lookup(st, tg, nw, 1'b1);
         end
      endfunction

      function void check_lookup(lookup_result_type got);
         lookup_result_type exp_r;
         bit                ok;
         if (expected_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: hit %0b miss %0b evict %0b last %0b",
                        got.hit, got.miss, got.eviction, got.last);
            return;
         end
         exp_r = expected_lookups.pop_front();
         ok = (got.hit == exp_r.hit) && (got.miss == exp_r.miss)
              && (got.eviction == exp_r.eviction) && (got.last == exp_r.last)
              && (got.hits == exp_r.hits) && (got.misses == exp_r.misses)
              && (got.evictions == exp_r.evictions);
         if (!ok) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("mismatch exp: hit %0b miss %0b evict %0b last %0b cnt %0d/%0d/%0d",
                        exp_r.hit, exp_r.miss, exp_r.eviction, exp_r.last,
                        exp_r.hits, exp_r.misses, exp_r.evictions);
               $display("         got: hit %0b miss %0b evict %0b last %0b cnt %0d/%0d/%0d",
                        got.hit, got.miss, got.eviction, got.last,
                        got.hits, got.misses, got.evictions);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_func = FUNC_LOAD;
   logic [31:0] req_address = '0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = CSR_SET_BITS;
   logic [4:0]  csr_wdata = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_hit;
   logic        rsp_miss;
   logic        rsp_eviction;
   logic        rsp_last_of_item;
   logic [31:0] rsp_hits_so_far;
   logic [31:0] rsp_misses_so_far;
   logic [31:0] rsp_evictions_so_far;
   logic        csr_ready;

   cache_model_type model;
   int              stall_cycles;
   logic [31:0]     tag_pool [12];
   logic [31:0]     set_pool [3];
   int unsigned     cur_set_bits;
   int unsigned     cur_block_bits;

   set_assoc_lru_cache_sim_unit #(
      .MAX_SET_BITS(SET_LIMIT),
      .MAX_WAYS(WAY_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_address(req_address),
      .rsp_valid(rsp_valid),
      .rsp_hit(rsp_hit),
      .rsp_miss(rsp_miss),
      .rsp_eviction(rsp_eviction),
      .rsp_last_of_item(rsp_last_of_item),
      .rsp_hits_so_far(rsp_hits_so_far),
      .rsp_misses_so_far(rsp_misses_so_far),
      .rsp_evictions_so_far(rsp_evictions_so_far),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result check first, then the access taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (rsp_valid)
            model.check_lookup('{rsp_hit, rsp_miss, rsp_eviction, rsp_last_of_item,
                                 rsp_hits_so_far, rsp_misses_so_far,
                                 rsp_evictions_so_far});
         if (start && !busy)
            model.note_access(req_func, req_address);
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            stall_cycles++;
         end
      end
   end

   task automatic send_access(input logic [1:0] func, input logic [31:0] addr);
      start       <= 1'b1;
      req_func    <= func;
      req_address <= addr;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(input int pct);
      if ($urandom_range(99) < pct) begin
         start       <= 1'b0;
         req_address <= $urandom;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
   endtask

   task automatic wait_results();
      start <= 1'b0;
      @(posedge clock);
      while (model.pending() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_results();
      while (busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [1:0] idx, input logic [4:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      model.write_reg(idx, val);
   endtask

   task automatic write_cfg(input logic [3:0] s, input logic [4:0] b, input logic [3:0] w);
      put_reg(CSR_SET_BITS, {1'b0, s});
      put_reg(CSR_BLOCK_BITS, b);
      put_reg(CSR_WAYS_IN_USE, {1'b0, w});
      csr_valid      <= 1'b0;
      cur_set_bits   = (s > SET_LIMIT) ? SET_LIMIT : s;
      cur_block_bits = b;
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      foreach (set_pool[i]) set_pool[i] = $urandom;
   endtask

   function automatic logic [31:0] pick_address();
      logic [63:0] a;
      logic [63:0] set_mask;
      logic [63:0] off_mask;
      if ($urandom_range(99) < 15) return $urandom;
      set_mask = (64'd1 << cur_set_bits) - 64'd1;
      off_mask = (64'd1 << cur_block_bits) - 64'd1;
      a = ({32'd0, tag_pool[$urandom_range(11)]} << (cur_set_bits + cur_block_bits))
          | (({32'd0, set_pool[$urandom_range(2)]} & set_mask) << cur_block_bits)
          | ({32'd0, $urandom} & off_mask);
      return a[31:0];
   endfunction

   function automatic logic [1:0] pick_func();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return FUNC_LOAD;
      if (r < 70) return FUNC_STORE;
      if (r < 95) return FUNC_MODIFY;
      return FUNC_NONE;
   endfunction

   initial begin
      int          pct;
      int          sent;
      logic [1:0]  func;
      logic [3:0]  s_val;
      logic [4:0]  b_val;
      logic [3:0]  w_val;
      model          = new();
      cur_set_bits   = SET_BITS_RST;
      cur_block_bits = BLOCK_BITS_RST;
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      foreach (set_pool[i]) set_pool[i] = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one way, hit after fill, eviction on tag change
      send_access(FUNC_LOAD, 32'h0000_0000);
      send_access(FUNC_LOAD, 32'h0000_0000);
      send_access(FUNC_STORE, 32'hFFFF_FFFF);
      send_access(FUNC_MODIFY, 32'hFFFF_FFFF);
      send_access(FUNC_LOAD, 32'h0000_0100);
      send_access(FUNC_NONE, 32'h0000_1234);
      send_access(FUNC_MODIFY, 32'h0000_0200);
      settle();

      // single set, all ways: fill, evict oldest, refresh on hit
      write_cfg(4'd0, 5'd0, 4'd8);
      for (int i = 1; i <= 9; i++) send_access(FUNC_LOAD, 32'(i));
      send_access(FUNC_STORE, 32'd3);
      send_access(FUNC_LOAD, 32'd1);
      settle();

      // oversized set bits with a split reaching the top bit
      write_cfg(4'd15, 5'd22, 4'd0);
      send_access(FUNC_MODIFY, 32'hFFFF_FFFF);
      send_access(FUNC_LOAD, 32'h0000_0000);
      settle();

      // split wider than the address, ways above the maximum
      write_cfg(4'd10, 5'd31, 4'd15);
      send_access(FUNC_LOAD, 32'h8000_0000);
      send_access(FUNC_STORE, 32'h7FFF_FFFF);
      settle();

      for (int ph = 0; ph < 9; ph++) begin
         pct   = (ph < 3) ? 18 : (ph < 6) ? 62 : 0;
         s_val = $urandom_range(15);
         b_val = $urandom_range(31);
         w_val = $urandom_range(15);
         if (ph == 0) begin
            s_val = 4'd0;  b_val = 5'd0;  w_val = 4'd8;
         end else if (ph == 4) begin
            s_val = 4'd10; b_val = 5'd22; w_val = 4'd8;
         end else if (ph == 8) begin
            s_val = 4'd15; b_val = 5'd31; w_val = 4'd0;
         end else if (b_val > 5'd20) begin
            b_val = $urandom_range(12);
         end
         write_cfg(s_val, b_val, w_val);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            func = pick_func();
            send_access(func, pick_address());
            if (func != FUNC_NONE) sent++;
            if (sent == PHASE_ITEMS / 2) begin
               // hold off until every expected transfer is in
               wait_results();
               sent++;
            end
            idle_gap(pct);
         end
         settle();
      end

      if (model.mismatch_count == 0 && model.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/slc_pkg.sv
hdl/slc_cfg.sv
hdl/slc_store.sv
hdl/set_assoc_lru_cache_sim_unit.sv
verif/set_assoc_lru_cache_sim_unit_tb.sv
